/* sv/text_terminal_scroll_buffer_macros.svh */
// Assertion macros used by the checker file of the terminal scroll buffer.
`ifndef TEXT_TERMINAL_SCROLL_BUFFER_MACROS_SVH
`define TEXT_TERMINAL_SCROLL_BUFFER_MACROS_SVH

// Same-cycle implication, clocked on aclk and disabled during reset.
`define TTSB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled during reset.
`define TTSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/ttsb_pkg.sv */
// Types, constants and codes of the terminal scroll buffer.
package ttsb_pkg;

    localparam int COLUMNS = 49;
    localparam int ROWS    = 16;
    localparam int ROW_W   = $clog2(ROWS);
    localparam int COL_W   = $clog2(COLUMNS + 1);
    localparam int CIDX_W  = $clog2(COLUMNS);
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam logic [1:0] REQ_PUT  = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_ACK  = 2'd2;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [3:0] read_row;
        logic [5:0] read_col;
    } req_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [5:0] row_length;
        logic [3:0] cursor_row;
        logic [5:0] cursor_col;
        logic       needs_redraw;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BLANK,
        ST_RADDR,
        ST_RDATA
    } state_t;

endpackage

/* sv/text_terminal_scroll_buffer.sv */
// Character-cell terminal buffer with cursor, per-row lengths and a dirty flag.
// After reset the block sweeps every cell of the screen to a space, one cell per
// cycle through the single write port of the cell memory, so s_ready stays low
// until all ROWS*COLUMNS cells (784) are swept. A put of CR, backspace, DEL or a
// printable byte that does not wrap, an acknowledge, and an unknown request leave
// the block idle: the result word is loaded at acceptance. A read forms the cell
// address in ST_RADDR and takes the registered memory read in ST_RDATA. A line
// feed, or a printable byte that wraps, blanks the row that the cursor moves to
// cell by cell in ST_BLANK; scrolling itself moves only a row offset. A new
// word is taken whenever the block is idle and the result register is empty or
// being read.
module text_terminal_scroll_buffer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  ttsb_pkg::req_t  s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output ttsb_pkg::rsp_t  m_data
);

    import ttsb_pkg::*;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    top_reg, top_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]    cur_phys_reg, cur_phys_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    logic [COL_W-1:0]    cur_len_reg, cur_len_next;
    logic [ADDR_W-1:0]   cur_base_reg, cur_base_next;
    logic                dirty_reg, dirty_next;
    logic [COL_W-1:0]    len_reg [ROWS];
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [CIDX_W-1:0]   bcol_reg, bcol_next;
    logic                pend_reg, pend_next;
    logic [7:0]          chr_reg, chr_next;
    logic [ROW_W-1:0]    rd_phys_reg, rd_phys_next;
    logic [CIDX_W-1:0]   rd_col_reg, rd_col_next;
    logic                rd_row_ok_reg, rd_row_ok_next;
    logic                rd_col_ok_reg, rd_col_ok_next;
    rsp_t                out_reg, out_next;
    logic                m_valid_reg, m_valid_next;

    logic                accept;
    logic                is_put, is_read, is_ack;
    logic                is_cr, is_lf, is_bs, is_prn;
    logic                col_full, advance, at_bottom;
    logic [ROW_W-1:0]    phys_inc, top_inc;
    logic [ADDR_W-1:0]   base_inc;
    logic [COL_W-1:0]    col_dec, col_inc;
    logic [ROW_W:0]      rd_sum;
    logic [ROW_W-1:0]    rd_phys;
    logic                len_we;
    logic [ROW_W-1:0]    len_widx;
    logic [COL_W-1:0]    len_wdata;
    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    ttsb_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign is_put    = (s_data.req_type == REQ_PUT);
    assign is_read   = (s_data.req_type == REQ_READ);
    assign is_ack    = (s_data.req_type == REQ_ACK);
    assign is_cr     = (s_data.char_code == CH_CR);
    assign is_lf     = (s_data.char_code == CH_LF);
    assign is_bs     = (s_data.char_code == CH_BS) || (s_data.char_code == CH_DEL);
    assign is_prn    = !is_cr && !is_lf && !is_bs;
    assign col_full  = (cur_col_reg >= COL_W'(COLUMNS));
    assign advance   = is_put && (is_lf || (is_prn && col_full));
    assign at_bottom = (cur_row_reg == ROW_W'(ROWS - 1));
    assign phys_inc  = (cur_phys_reg == ROW_W'(ROWS - 1)) ? '0 : cur_phys_reg + 1'b1;
    assign top_inc   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
    assign base_inc  = (cur_phys_reg == ROW_W'(ROWS - 1)) ? '0
                                                          : cur_base_reg + ADDR_W'(COLUMNS);
    assign col_dec   = cur_col_reg - 1'b1;
    assign col_inc   = cur_col_reg + 1'b1;
    assign rd_sum    = {1'b0, top_reg} + {1'b0, ROW_W'(s_data.read_row)};
    assign rd_phys   = (rd_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(rd_sum - (ROW_W + 1)'(ROWS))
                                                      : rd_sum[ROW_W-1:0];

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_addr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && is_read) begin
                    state_next = ST_RADDR;
                end else if (accept && advance) begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                if (bcol_reg == CIDX_W'(COLUMNS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_RADDR: begin
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = CH_SPACE;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
            end
            ST_IDLE: begin
                if (accept && is_put && !advance && is_prn) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_base_reg + ADDR_W'(cur_col_reg);
                    ram_wdata = s_data.char_code;
                end else if (accept && is_put && is_bs && (cur_col_reg != '0)) begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_base_reg + ADDR_W'(col_dec);
                end
            end
            ST_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = cur_base_reg + ADDR_W'(bcol_reg);
                ram_wdata = (pend_reg && (bcol_reg == '0)) ? chr_reg : CH_SPACE;
            end
            ST_RADDR: begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(ADDR_W'(rd_phys_reg) * ADDR_W'(COLUMNS))
                          + (rd_col_ok_reg ? ADDR_W'(rd_col_reg) : '0);
            end
            ST_RDATA: begin
                ram_re = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        top_next       = top_reg;
        cur_row_next   = cur_row_reg;
        cur_phys_next  = cur_phys_reg;
        cur_col_next   = cur_col_reg;
        cur_len_next   = cur_len_reg;
        cur_base_next  = cur_base_reg;
        dirty_next     = dirty_reg;
        clr_addr_next  = clr_addr_reg;
        bcol_next      = bcol_reg;
        pend_next      = pend_reg;
        chr_next       = chr_reg;
        rd_phys_next   = rd_phys_reg;
        rd_col_next    = rd_col_reg;
        rd_row_ok_next = rd_row_ok_reg;
        rd_col_ok_next = rd_col_ok_reg;
        len_we         = 1'b0;
        len_widx       = cur_phys_reg;
        len_wdata      = '0;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;

        if (state_reg == ST_CLEAR) begin
            clr_addr_next = clr_addr_reg + 1'b1;
        end
        if (state_reg == ST_BLANK) begin
            bcol_next = bcol_reg + 1'b1;
        end

        if (accept) begin
            if (is_put) begin
                dirty_next = 1'b1;
                priority if (advance) begin
                    cur_col_next  = is_prn ? COL_W'(1) : '0;
                    if (at_bottom) begin
                        top_next = top_inc;
                    end else begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                    cur_phys_next = phys_inc;
                    cur_base_next = base_inc;
                    cur_len_next  = cur_col_next;
                    len_we        = 1'b1;
                    len_widx      = phys_inc;
                    len_wdata     = cur_col_next;
                    pend_next     = is_prn;
                    chr_next      = s_data.char_code;
                    bcol_next     = '0;
                end else if (is_cr) begin
                    cur_col_next = '0;
                end else if (is_bs) begin
                    if (cur_col_reg != '0) begin
                        cur_col_next = col_dec;
                        cur_len_next = col_dec;
                        len_we       = 1'b1;
                        len_wdata    = col_dec;
                    end
                end else begin
                    cur_col_next = col_inc;
                    if (col_inc > cur_len_reg) begin
                        cur_len_next = col_inc;
                        len_we       = 1'b1;
                        len_wdata    = col_inc;
                    end
                end
            end else if (is_read) begin
                rd_phys_next   = rd_phys;
                rd_col_next    = CIDX_W'(s_data.read_col);
                rd_row_ok_next = (32'(s_data.read_row) < ROWS);
                rd_col_ok_next = (32'(s_data.read_col) < COLUMNS);
            end else if (is_ack) begin
                dirty_next = 1'b0;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && !is_read) begin
            out_next.cell_char    = '0;
            out_next.row_length   = '0;
            out_next.cursor_row   = 4'(cur_row_next);
            out_next.cursor_col   = 6'(cur_col_next);
            out_next.needs_redraw = dirty_next;
            m_valid_next          = 1'b1;
        end
        if (state_reg == ST_RDATA) begin
            out_next.cell_char    = (rd_row_ok_reg && rd_col_ok_reg) ? ram_rdata : '0;
            out_next.row_length   = rd_row_ok_reg ? 6'(len_reg[rd_phys_reg]) : '0;
            out_next.cursor_row   = 4'(cur_row_reg);
            out_next.cursor_col   = 6'(cur_col_reg);
            out_next.needs_redraw = dirty_reg;
            m_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            top_reg      <= '0;
            cur_row_reg  <= '0;
            cur_phys_reg <= '0;
            cur_col_reg  <= '0;
            cur_len_reg  <= '0;
            cur_base_reg <= '0;
            dirty_reg    <= 1'b1;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < ROWS; i++) begin
                len_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            top_reg      <= top_next;
            cur_row_reg  <= cur_row_next;
            cur_phys_reg <= cur_phys_next;
            cur_col_reg  <= cur_col_next;
            cur_len_reg  <= cur_len_next;
            cur_base_reg <= cur_base_next;
            dirty_reg    <= dirty_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            if (len_we) begin
                len_reg[len_widx] <= len_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bcol_reg      <= bcol_next;
        pend_reg      <= pend_next;
        chr_reg       <= chr_next;
        rd_phys_reg   <= rd_phys_next;
        rd_col_reg    <= rd_col_next;
        rd_row_ok_reg <= rd_row_ok_next;
        rd_col_ok_reg <= rd_col_ok_next;
        out_reg       <= out_next;
    end

endmodule

/* sv/ttsb_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module ttsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 784
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/ttsb_checker.sv */
// Port-level checker of the terminal scroll buffer and its bind statement.
`include "text_terminal_scroll_buffer_macros.svh"

module ttsb_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input ttsb_pkg::req_t  s_data,
    input logic            m_valid,
    input logic            m_ready,
    input ttsb_pkg::rsp_t  m_data
);

    import ttsb_pkg::*;

    `TTSB_ASSERT_IMP(a_ready_room, s_ready, !m_valid || m_ready, "input ready while result blocked")
    `TTSB_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed")
    `TTSB_ASSERT_NEXT(a_ack_clear, s_valid && s_ready && s_data.req_type == REQ_ACK, m_valid && !m_data.needs_redraw, "acknowledge left dirty flag set")
    `TTSB_ASSERT_NEXT(a_put_result, s_valid && s_ready && s_data.req_type == REQ_PUT, m_valid && m_data.needs_redraw && m_data.cell_char == 8'd0 && m_data.row_length == 6'd0, "bad put result")
    `TTSB_ASSERT_IMP(a_col_range, m_valid, 32'(m_data.cursor_col) <= COLUMNS, "cursor column out of range")

endmodule

bind text_terminal_scroll_buffer ttsb_checker u_ttsb_checker (.*);
